FILE: rtl/rfw_pkg.sv
// Shared types, constants and formats of the reconstruction filter weight block.
package rfw_pkg;

  // Field widths of the ports
  localparam int OFFSET_W  = 16;
  localparam int WEIGHT_W  = 16;
  localparam int MODE_W    = 2;

  // Fixed-point formats
  localparam int OFFSET_FRAC_BITS = 12;
  localparam int WEIGHT_FRAC_BITS = 14;

  // Magnitude of the offset, 0..32768
  localparam int ABS_W = OFFSET_W;

  // Internal signed weight, wide enough for +/- 2^WEIGHT_FRAC_BITS
  localparam int WW = WEIGHT_FRAC_BITS + 2;

  // Gaussian table
  localparam int GAUSS_DEPTH_DEFAULT = 256;
  localparam int GIDX_W = 13;
  localparam longint unsigned Q31_ONE = 64'd2147483648;
  localparam longint unsigned GAUSS_PEAK_Q31 = 64'd1713444131;

  typedef enum logic [MODE_W-1:0] {
    MODE_BOX      = 2'd0,
    MODE_TENT     = 2'd1,
    MODE_GAUSS    = 2'd2,
    MODE_MITCHELL = 2'd3
  } filter_mode_t;

  localparam filter_mode_t MODE_RESET = MODE_MITCHELL;

  // One classified item on its way from front to back
  typedef struct packed {
    filter_mode_t              mode;
    logic [ABS_W-1:0]          a;
    logic                      gauss_in;
    logic                      mitch_near;
    logic                      mitch_in;
    logic [GIDX_W-1:0]         gidx;
    logic signed [WW-1:0]      simple_wgt;
  } rfw_item_t;

endpackage

FILE: rtl/rfw_front.sv
// Front end: command intake, mode register, offset classification.
module rfw_front #(
  parameter int GAUSS_TABLE_DEPTH = rfw_pkg::GAUSS_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [rfw_pkg::OFFSET_W-1:0] x_offset,
  output logic                              busy,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rfw_pkg::MODE_W-1:0]        cfg_data,
  input  logic                              q_ready,
  output logic                              q_valid,
  output rfw_pkg::rfw_item_t                q_item
);
  import rfw_pkg::*;

  localparam int S       = OFFSET_FRAC_BITS;
  localparam int W       = WEIGHT_FRAC_BITS;
  localparam int IW      = $clog2(GAUSS_TABLE_DEPTH + 1);
  localparam int PW      = ABS_W + IW + 1;
  localparam int TW      = S + W + 2;
  localparam int ONE     = 1 << S;
  localparam int HALF_S  = 1 << (S - 1);

  filter_mode_t       mode;
  logic               pend;
  logic [OFFSET_W-1:0] x_q;
  logic               accept;
  logic               push;

  logic [ABS_W-1:0]   a;
  logic [TW-1:0]      tent_full;
  logic [PW-1:0]      gidx_full;
  logic [IW-1:0]      gidx;
  logic signed [WW-1:0] simple_wgt;

  assign cfg_ready = 1'b1;
  assign push      = pend && q_ready;
  assign busy      = pend && !q_ready;
  assign accept    = start && !busy;

  // Hold the filter mode
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mode <= filter_mode_t'(cfg_data);
    end
  end

  // Capture one item, hold it until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (accept) begin
      pend <= 1'b1;
    end else if (push) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_q <= x_offset;
    end
  end

  // Classify the held offset
  always_comb begin
    a = x_q[OFFSET_W-1] ? (~x_q + 16'd1) : x_q;
    tent_full = (((TW'(ONE) - TW'(a)) << W) + TW'(HALF_S)) >> S;
    gidx_full = ((PW'(a) * PW'(GAUSS_TABLE_DEPTH)) + PW'(ONE)) >> (S + 1);
    gidx = (32'(a) <= 2 * ONE) ? gidx_full[IW-1:0] : '0;
    case (mode)
      MODE_BOX: begin
        simple_wgt = (32'(a) < (ONE >> 1)) ? WW'(1 << W) : '0;
      end
      MODE_TENT: begin
        simple_wgt = (32'(a) < ONE) ? WW'(tent_full) : '0;
      end
      default: begin
        simple_wgt = '0;
      end
    endcase
  end

  always_comb begin
    q_valid             = pend;
    q_item.mode         = mode;
    q_item.a            = a;
    q_item.gauss_in     = (32'(a) <= 2 * ONE);
    q_item.mitch_near   = (32'(a) < ONE);
    q_item.mitch_in     = (32'(a) < 2 * ONE);
    q_item.gidx         = GIDX_W'(gidx);
    q_item.simple_wgt   = simple_wgt;
  end

endmodule

FILE: rtl/rfw_queue.sv
// Two-entry item queue between the front end and the back end.
module rfw_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rfw_pkg::rfw_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output rfw_pkg::rfw_item_t out_item
);
  import rfw_pkg::*;

  rfw_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Store the incoming item
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

FILE: rtl/rfw_back.sv
// Back end: Gaussian table lookup, Mitchell-Netravali cubic pipeline and weight selection by mode.
module rfw_back #(
  parameter int GAUSS_TABLE_DEPTH = rfw_pkg::GAUSS_DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  input  rfw_pkg::rfw_item_t                 item,
  output logic                               item_pop,
  output logic                               done,
  output logic signed [rfw_pkg::WEIGHT_W-1:0] weight
);
  import rfw_pkg::*;

  localparam int S   = OFFSET_FRAC_BITS;
  localparam int W   = WEIGHT_FRAC_BITS;
  localparam int IW  = $clog2(GAUSS_TABLE_DEPTH + 1);
  localparam int AW  = 2 * S + 4;
  localparam int NW  = 2 * S + 10;
  localparam int SW  = NW + W + 1;
  localparam int QW  = W + 5;
  localparam int K   = QW + 5;
  localparam int RW  = K - 4;
  localparam int PW  = QW + RW;
  localparam int TQW = QW - 4;
  localparam longint unsigned GAUSS_DEPTH_SQ =
    longint'(GAUSS_TABLE_DEPTH) * longint'(GAUSS_TABLE_DEPTH);

  localparam logic signed [NW-1:0] K7     = NW'(7);
  localparam logic signed [NW-1:0] K21    = NW'(21);
  localparam logic signed [NW-1:0] K36    = NW'(36);
  localparam logic signed [NW-1:0] K60    = NW'(60);
  localparam logic signed [NW-1:0] NEAR_C = NW'(16) << (2 * S);
  localparam logic signed [NW-1:0] FAR_C  = NW'(32) << (2 * S);
  localparam logic [SW-1:0]        ROUND_ADD = SW'(9) << (2 * S);
  localparam logic [RW-1:0]        RECIP = RW'((64'd1 << K) / 18);
  localparam logic [QW-1:0]        DIV_18 = QW'(18);

  typedef logic [W-1:0] gauss_rom_t [GAUSS_TABLE_DEPTH+1];

  // Divide a series term by its small index
  function automatic longint unsigned div_by_k(longint unsigned x, int k);
    longint unsigned r;
    case (k)
      1:       r = x;
      2:       r = x / 2;
      3:       r = x / 3;
      4:       r = x / 4;
      5:       r = x / 5;
      6:       r = x / 6;
      7:       r = x / 7;
      8:       r = x / 8;
      9:       r = x / 9;
      10:      r = x / 10;
      11:      r = x / 11;
      12:      r = x / 12;
      13:      r = x / 13;
      14:      r = x / 14;
      15:      r = x / 15;
      16:      r = x / 16;
      default: r = x;
    endcase
    return r;
  endfunction

  // exp(-2x^2) at x = 2i/D, scaled by the Gaussian peak, in Q0.W
  function automatic logic [W-1:0] gauss_entry(longint unsigned i);
    longint unsigned u;
    longint unsigned term;
    longint unsigned e;
    int k;
    int n;
    u = ((i * i) << 31) / GAUSS_DEPTH_SQ;
    term = Q31_ONE;
    e = Q31_ONE;
    for (k = 1; k <= 16; k++) begin
      term = div_by_k((term * u) >> 31, k);
      if (k[0]) begin
        e = e - term;
      end else begin
        e = e + term;
      end
    end
    for (n = 0; n < 3; n++) begin
      e = (e * e + (Q31_ONE >> 1)) >> 31;
    end
    return W'((e * GAUSS_PEAK_Q31 + (64'd1 << (61 - W))) >> (62 - W));
  endfunction

  function automatic gauss_rom_t build_gauss_rom();
    gauss_rom_t r;
    for (int i = 0; i <= GAUSS_TABLE_DEPTH; i++) begin
      r[i] = gauss_entry(longint'(i));
    end
    return r;
  endfunction

  localparam gauss_rom_t GAUSS_ROM = build_gauss_rom();

  // Pipeline registers
  logic                 v1, v2, v3, v4, v5;
  rfw_item_t            it1, it2, it3, it4, it5;
  logic [W-1:0]         rom1, rom2, rom3, rom4, rom5;
  logic [2*ABS_W-1:0]   a2_1;
  logic [AW-1:0]        a2_2, a3_2;
  logic signed [NW-1:0] n_3;
  logic                 neg4, neg5;
  logic [QW-1:0]        q_4, q_5;
  logic [PW-1:0]        p_5;

  // Stage logic
  logic [3*ABS_W-1:0]   a3_full;
  logic signed [NW-1:0] a2s, a3s, as_s;
  logic signed [NW-1:0] n_near, n_far;
  logic [NW-1:0]        m;
  logic [SW-1:0]        scaled;
  logic [TQW-1:0]       qa;
  logic [QW-1:0]        rem;
  logic [TQW-1:0]       t;
  logic signed [WW-1:0] mitch_wgt;
  logic signed [WW-1:0] wsel;

  assign item_pop = item_valid;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= item_valid;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      done <= v5;
    end
  end

  // Square the offset, read the table
  always_ff @(posedge clk) begin
    it1  <= item;
    a2_1 <= (2*ABS_W)'(item.a) * (2*ABS_W)'(item.a);
    rom1 <= GAUSS_ROM[item.gidx[IW-1:0]];
  end

  // Cube the offset
  assign a3_full = (3*ABS_W)'(a2_1) * (3*ABS_W)'(it1.a);

  always_ff @(posedge clk) begin
    it2  <= it1;
    rom2 <= rom1;
    a2_2 <= AW'(a2_1);
    a3_2 <= a3_full[S +: AW];
  end

  // Form the cubic numerator for the inner and outer lobes
  always_comb begin
    a2s    = NW'(a2_2);
    a3s    = NW'(a3_2);
    as_s   = NW'(it2.a);
    n_near = K21 * a3s - K36 * a2s + NEAR_C;
    n_far  = K36 * a2s - K7 * a3s - ((K60 * as_s) <<< S) + FAR_C;
  end

  always_ff @(posedge clk) begin
    it3  <= it2;
    rom3 <= rom2;
    n_3  <= it2.mitch_near ? n_near : n_far;
  end

  // Scale the magnitude to the weight format with the rounding offset
  always_comb begin
    m      = n_3[NW-1] ? NW'(-n_3) : NW'(n_3);
    scaled = (SW'(m) << W) + ROUND_ADD;
  end

  always_ff @(posedge clk) begin
    it4  <= it3;
    rom4 <= rom3;
    neg4 <= n_3[NW-1];
    q_4  <= scaled[2*S +: QW];
  end

  // Multiply by the reciprocal of 18
  always_ff @(posedge clk) begin
    it5  <= it4;
    rom5 <= rom4;
    neg5 <= neg4;
    q_5  <= q_4;
    p_5  <= PW'(q_4) * PW'(RECIP);
  end

  // Correct the quotient, restore the sign, select by mode
  always_comb begin
    qa        = p_5[K +: TQW];
    rem       = q_5 - DIV_18 * QW'(qa);
    t         = (rem >= DIV_18) ? (qa + TQW'(1)) : qa;
    mitch_wgt = neg5 ? -WW'(t) : WW'(t);
    case (it5.mode)
      MODE_GAUSS: begin
        wsel = it5.gauss_in ? WW'(rom5) : '0;
      end
      MODE_MITCHELL: begin
        wsel = it5.mitch_in ? mitch_wgt : '0;
      end
      default: begin
        wsel = it5.simple_wgt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    weight <= WEIGHT_W'(wsel);
  end

endmodule

FILE: rtl/reconstruction_filter_weight_core.sv
// Top level of the reconstruction filter weight block.
//
//   channel   direction  handshake                   payload
//   command   in         start, busy                 x_offset
//   result    out        done (one-cycle strobe)     weight
//   config    in         cfg_valid, cfg_ready        cfg_data (filter_mode)
//
// One item per cycle; the item passes the front register, which takes it at the
// accepting edge, a queue slot and six back stages set by the Mitchell cubic
// and the divide-by-18 multiply, and done rises when the last one takes it. The back
// end pops the queue every cycle and the receiver cannot hold results off, so
// the queue never fills and busy stays low.
// Synchronous reset clears control state and sets filter_mode to Mitchell.
module reconstruction_filter_weight_core #(
  parameter int GAUSS_TABLE_DEPTH = rfw_pkg::GAUSS_DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [rfw_pkg::OFFSET_W-1:0] x_offset,
  output logic                               done,
  output logic signed [rfw_pkg::WEIGHT_W-1:0] weight,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rfw_pkg::MODE_W-1:0]         cfg_data
);
  import rfw_pkg::*;

  logic      f_valid;
  logic      f_ready;
  rfw_item_t f_item;
  logic      b_valid;
  logic      b_pop;
  rfw_item_t b_item;

  // Accept and classify items
  rfw_front #(
    .GAUSS_TABLE_DEPTH (GAUSS_TABLE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .x_offset  (x_offset),
    .busy      (busy),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_ready   (f_ready),
    .q_valid   (f_valid),
    .q_item    (f_item)
  );

  // Buffer items between front and back
  rfw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (b_valid),
    .out_ready (b_pop),
    .out_item  (b_item)
  );

  // Evaluate the kernel
  rfw_back #(
    .GAUSS_TABLE_DEPTH (GAUSS_TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (b_valid),
    .item       (b_item),
    .item_pop   (b_pop),
    .done       (done),
    .weight     (weight)
  );

endmodule
